[rtl/shs_pkg.sv]
// shared types, constants and round functions of the sha-256 stream hasher
// no dependencies; imported by every module of the block
package shs_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned VB_W    = 3;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NBITS_W = 6;
  localparam int unsigned ROUNDS  = 64;

  localparam logic [VB_W-1:0]    VB_FULL   = 3'd4;
  localparam logic [NBITS_W-1:0] BITS_WORD = 6'd32;
  localparam logic [7:0]         PAD_BYTE  = 8'h80;
  localparam logic [WORD_W-1:0]  PAD_WORD  = 32'h8000_0000;

  localparam logic [3:0] WIB_LAST = 4'd15;
  localparam logic [3:0] WIB_LEN  = 4'd14;
  localparam logic [5:0] RND_LAST = 6'd63;
  localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

  localparam logic [WORD_W-1:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [1:0] {
    ITEM_DATA,        // plain message word
    ITEM_FINAL_PAD,   // final word, pad byte already merged in
    ITEM_FINAL_FULL   // final word of four bytes, pad word still to follow
  } item_kind_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    item_kind_t         kind;
    logic [NBITS_W-1:0] nbits;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_LENLO,
    ST_ROUND,
    ST_HADD,
    ST_EMIT
  } back_state_t;

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x, input int n);
    ror = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WORD_W-1:0] ch(input logic [WORD_W-1:0] e,
                                           input logic [WORD_W-1:0] f,
                                           input logic [WORD_W-1:0] g);
    ch = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [WORD_W-1:0] maj(input logic [WORD_W-1:0] a,
                                            input logic [WORD_W-1:0] b,
                                            input logic [WORD_W-1:0] c);
    maj = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

[rtl/sha256_stream_hasher.sv]
// top level of the sha-256 stream hasher: front classifier, word queue, compression back end
// depends on shs_pkg, shs_front, shs_fifo, shs_back
//
//  channel | dir | tdata                 | tuser            | tlast
//  s_*     | in  | [31:0] data_word      | [2:0] valid_bytes | end_of_message
//  m_*     | out | [31:0] digest_word    | [2:0] word_index  | last_word
//
// the sixteenth word of a block starts the 64 rounds of the single round unit, then the
// chaining add; the back end pops no further word from the queue until both are done.
// the final word adds padding pushes, one or two compressions, then eight digest words.
// rst is synchronous and restores the initial hash values and an empty block.
// the word queue keeps input flowing, until it fills, while the back end compresses or output stalls.
module sha256_stream_hasher import shs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [WORD_W-1:0]  s_tdata,   // data_word
  input  logic [VB_W-1:0]    s_tuser,   // valid_bytes
  input  logic               s_tlast,   // end_of_message
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [WORD_W-1:0]  m_tdata,   // digest_word
  output logic [IDX_W-1:0]   m_tuser,   // word_index
  output logic               m_tlast    // last_word
);

  logic     wr_valid;
  logic     wr_ready;
  q_entry_t wr_data;
  logic     rd_valid;
  logic     rd_ready;
  q_entry_t rd_data;

  shs_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  shs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  shs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (rd_valid),
    .q_pop    (rd_ready),
    .q_data   (rd_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[rtl/shs_front.sv]
// input classifier: masks the final word, merges the pad byte, gives each word's count of message bits
// depends on shs_pkg
module shs_front import shs_pkg::*; (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [WORD_W-1:0]   s_tdata,
  input  logic [VB_W-1:0]     s_tuser,
  input  logic                s_tlast,
  output logic                wr_valid,
  input  logic                wr_ready,
  output q_entry_t            wr_data
);

  logic [VB_W-1:0] vb;

  assign s_tready = wr_ready;
  assign wr_valid = s_tvalid;

  always_comb begin
    vb = (s_tuser > VB_FULL) ? VB_FULL : s_tuser;
    wr_data.word  = s_tdata;
    wr_data.kind  = ITEM_DATA;
    wr_data.nbits = BITS_WORD;
    if (s_tlast) begin
      wr_data.nbits = {vb, 3'b000};
      wr_data.kind  = ITEM_FINAL_PAD;
      case (vb)
        3'd0:    wr_data.word = PAD_WORD;
        3'd1:    wr_data.word = {s_tdata[31:24], PAD_BYTE, 16'h0000};
        3'd2:    wr_data.word = {s_tdata[31:16], PAD_BYTE, 8'h00};
        3'd3:    wr_data.word = {s_tdata[31:8], PAD_BYTE};
        default: wr_data.kind = ITEM_FINAL_FULL;
      endcase
    end
  end

endmodule

[rtl/shs_fifo.sv]
// short queue of classified words between the front and the compression back end
// depends on shs_pkg
module shs_fifo import shs_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  q_entry_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output q_entry_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  q_entry_t      mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (cnt != CNT_FULL);
  assign rd_valid = (cnt != '0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[rtl/shs_back.sv]
// back end: block buffer, padding sequencer, one-round-per-cycle compression, digest output
// depends on shs_pkg
module shs_back import shs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  q_entry_t           q_data,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [WORD_W-1:0]  m_tdata,    // digest_word
  output logic [IDX_W-1:0]   m_tuser,    // word_index
  output logic               m_tlast     // last_word
);

  back_state_t       state, state_next;
  back_state_t       ret, ret_next;
  back_state_t       dest;

  logic [WORD_W-1:0] hash [8];
  logic [WORD_W-1:0] blk  [16];
  logic [WORD_W-1:0] wv   [8];
  logic [WORD_W-1:0] win  [16];
  logic [3:0]        wib;
  logic [63:0]       count;
  logic [5:0]        rnd;
  logic [IDX_W-1:0]  idx;

  logic              push_en;
  logic [WORD_W-1:0] push_word;
  logic              load_out;
  logic              out_free;

  logic [WORD_W-1:0] w_t;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;

  assign out_free = !m_tvalid || m_tready;

  // next state; a push that fills the block detours through compression
  always_comb begin
    state_next = state;
    ret_next   = ret;
    dest       = state;
    unique case (state)
      ST_IDLE: begin
        unique case (q_data.kind)
          ITEM_DATA:       dest = ST_IDLE;
          ITEM_FINAL_PAD:  dest = ST_PADZ;
          ITEM_FINAL_FULL: dest = ST_PAD80;
          default:         dest = ST_IDLE;
        endcase
      end
      ST_PAD80: dest = ST_PADZ;
      ST_PADZ:  dest = (wib == WIB_LEN) ? ST_LENLO : ST_PADZ;
      ST_LENLO: dest = ST_EMIT;
      default:  dest = state;
    endcase
    unique case (state)
      ST_IDLE, ST_PAD80, ST_PADZ, ST_LENLO: begin
        if (push_en) begin
          if (wib == WIB_LAST) begin
            state_next = ST_ROUND;
            ret_next   = dest;
          end else begin
            state_next = dest;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == RND_LAST) begin
          state_next = ST_HADD;
        end
      end
      ST_HADD: state_next = ret;
      ST_EMIT: begin
        if (out_free && idx == IDX_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        push_en   = q_valid;
        q_pop     = q_valid;
        push_word = q_data.word;
      end
      ST_PAD80: begin
        push_en   = 1'b1;
        push_word = PAD_WORD;
      end
      ST_PADZ: begin
        push_en   = 1'b1;
        push_word = (wib == WIB_LEN) ? count[63:32] : '0;
      end
      ST_LENLO: begin
        push_en   = 1'b1;
        push_word = count[31:0];
      end
      ST_EMIT:  load_out = out_free;
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  // one compression round
  always_comb begin
    if (rnd < 6'd16) begin
      w_t = blk[rnd[3:0]];
    end else begin
      w_t = win[0] + ssig0(win[1]) + win[9] + ssig1(win[14]);
    end
    t1 = wv[7] + bsig1(wv[4]) + ch(wv[4], wv[5], wv[6]) + ROUND_K[rnd] + w_t;
    t2 = bsig0(wv[0]) + maj(wv[0], wv[1], wv[2]);
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      blk[wib] <= push_word;
      if (wib == WIB_LAST) begin
        for (int i = 0; i < 8; i++) begin
          wv[i] <= hash[i];
        end
        rnd <= '0;
      end
    end
    if (state == ST_ROUND) begin
      rnd   <= rnd + 1'b1;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
      // window holds the last sixteen schedule words, newest at the top
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_t;
    end
    if (load_out) begin
      m_tdata <= hash[idx];
      m_tuser <= idx;
      m_tlast <= (idx == IDX_LAST);
    end

    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      wib      <= '0;
      count    <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= H_INIT[i];
      end
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (push_en) begin
        wib <= wib + 1'b1;
      end
      if (q_pop) begin
        count <= count + {58'd0, q_data.nbits};
      end
      if (state == ST_HADD) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + wv[i];
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
        idx      <= idx + 1'b1;
        // last digest word captured: start the next message fresh
        if (idx == IDX_LAST) begin
          count <= '0;
          for (int i = 0; i < 8; i++) begin
            hash[i] <= H_INIT[i];
          end
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
